// File: src/bcdcal_pkg.sv
// ----------------------------------------------------------------------------
// bcdcal_pkg: shared types and constants for the BCD calendar converter
// Item layouts, status codes, register indexes, reset values and the
// calendar helper functions used by the converter and its interfaces.
// ----------------------------------------------------------------------------
package bcdcal_pkg;

  // Register index port width and register codes
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    RegEpochBase = 1'b0,
    RegEpochYear = 1'b1
  } reg_idx_e;

  // Result status codes
  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatHeld  = 2'd1,
    StatRange = 2'd2
  } status_e;

  // Register reset values
  localparam logic [31:0] EpochBaseReset = 32'd1420070400;
  localparam logic [6:0]  EpochYearReset = 7'd15;

  // Time constants
  localparam logic [16:0] SecPerDay   = 17'd86400;
  localparam logic [8:0]  DaysPerYear = 9'd365;
  localparam logic [5:0]  SecPerMin   = 6'd60;

  // Days before months 2..12 in a common year
  localparam logic [8:0] DaysBefore [11] = '{
    9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // One input item: six raw BCD register bytes
  typedef struct packed {
    logic [7:0] seconds_reg;
    logic [7:0] minutes_reg;
    logic [7:0] hours_reg;
    logic [7:0] day_reg;
    logic [7:0] month_reg;
    logic [7:0] year_reg;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [31:0] timestamp;
    logic [1:0]  status;
  } out_item_t;

  // Decoded calendar time
  typedef struct packed {
    logic [6:0] sec;
    logic [6:0] min;
    logic [5:0] hr;
    logic [5:0] day;
    logic [4:0] mon;
    logic [7:0] yr;
  } cal_time_t;

  // Leap test on a decoded year below 200: year 0 counts, year 100 does not
  function automatic logic is_leap(logic [7:0] y);
    return (y[1:0] == 2'b00) && (y != 8'd100);
  endfunction

  // Days before the given month (month known to be 1..12)
  function automatic logic [8:0] days_before_month(logic [4:0] mon);
    logic [4:0] idx;
    idx = mon - 5'd2;
    if (mon <= 5'd1) begin
      return 9'd0;
    end
    return DaysBefore[idx[3:0]];
  endfunction

endpackage

// File: src/bcdcal_if.sv
// ----------------------------------------------------------------------------
// bcdcal_if: handshake channels of the BCD calendar converter
// Input item channel, result channel and register write channel, each
// with valid, ready and payload.
// ----------------------------------------------------------------------------
interface bcdcal_in_if;
  import bcdcal_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bcdcal_out_if;
  import bcdcal_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bcdcal_cfg_if;
  import bcdcal_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [31:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/bcd_calendar_to_epoch_seconds_top.sv
// ----------------------------------------------------------------------------
// bcd_calendar_to_epoch_seconds_top: BCD calendar to epoch seconds
// Converts six BCD calendar register bytes into seconds since a
// configurable epoch using one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one item of six BCD bytes (seconds .. two-digit year).
//   out_o  : one result per item, 32-bit timestamp and 2-bit status
//            (ok, day byte zero so held time used, out of range).
//   cfg_i  : register writes, index 0 epoch base seconds, index 1 epoch
//            year; always ready, write only while the converter is idle.
// Sequence: an accepted item walks the year span one year per cycle, from
//   the epoch year up to the held year, then adds the month and day, turns
//   days into seconds and adds the time of day; an out-of-range item goes
//   from the range check straight to the finish step, with no year walk.
// Throughput: one item at a time; in_i.ready is high only while idle.
// Reset: held time returns to 00:00:00 1 January of year 15, the epoch
//   registers to their defaults, and no result is pending.
// Stall: a finished result waits in the output register; the sequencer
//   holds in its last step until that register is free.
// ----------------------------------------------------------------------------
module bcd_calendar_to_epoch_seconds_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  bcdcal_in_if.sink    in_i,
  bcdcal_out_if.source out_o,
  bcdcal_cfg_if.sink   cfg_i
);
  import bcdcal_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StYears,
    StMonth,
    StMul,
    StTod,
    StFinish
  } state_e;

  state_e      state_q;
  logic [31:0] epoch_base_q;
  logic [6:0]  epoch_year_q;
  cal_time_t   held_q;
  cal_time_t   dec_time;
  status_e     status_q;
  logic [7:0]  year_q;
  logic [31:0] days_q;
  logic [31:0] acc_q;
  logic [11:0] tod_q;
  logic        out_valid_q;
  out_item_t   out_item_q;

  logic        range_err;
  logic [31:0] add_b;
  logic [31:0] add_sum;
  logic [31:0] prod_full;
  logic [17:0] tod_secs;

  // Decode the incoming register bytes
  bcdcal_decode u_decode (
    .item_i (in_i.item),
    .time_o (dec_time)
  );

  // Register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_base_q <= EpochBaseReset;
      epoch_year_q <= EpochYearReset;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        RegEpochBase: epoch_base_q <= cfg_i.data;
        RegEpochYear: epoch_year_q <= cfg_i.data[6:0];
        default: ;
      endcase
    end
  end

  // Range check on the held time
  assign range_err = (held_q.mon < 5'd1) || (held_q.mon > 5'd12) ||
                     (held_q.yr < {1'b0, epoch_year_q});

  // Select the addend for the shared day/second adder
  always_comb begin
    case (state_q)
      StYears: add_b = 32'(DaysPerYear) + 32'(is_leap(year_q));
      StMonth: add_b = 32'(days_before_month(held_q.mon)) +
                       32'((held_q.mon > 5'd2) && is_leap(held_q.yr)) +
                       32'(held_q.day) - 32'd1;
      StTod:   add_b = 32'(tod_secs);
      default: add_b = epoch_base_q;
    endcase
  end

  assign add_sum   = ((state_q == StTod) || (state_q == StFinish) ? acc_q : days_q) + add_b;
  assign prod_full = days_q * 32'(SecPerDay);
  assign tod_secs  = 18'(tod_q) * 18'(SecPerMin) + 18'(held_q.sec);

  // Sequencer, held time and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      held_q      <= '{sec: 7'd0, min: 7'd0, hr: 6'd0, day: 6'd1, mon: 5'd1, yr: 8'd15};
      status_q    <= StatOk;
      year_q      <= '0;
      days_q      <= '0;
      acc_q       <= '0;
      tod_q       <= '0;
    end else begin
      // Drop the result once taken, unless a new one replaces it
      if (out_valid_q && out_o.ready && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            if (in_i.item.day_reg != 8'd0) begin
              held_q   <= dec_time;
              status_q <= StatOk;
            end else begin
              status_q <= StatHeld;
            end
            state_q <= StCheck;
          end
        end
        StCheck: begin
          if (range_err) begin
            status_q <= StatRange;
            state_q  <= StFinish;
          end else begin
            days_q  <= '0;
            year_q  <= {1'b0, epoch_year_q};
            state_q <= StYears;
          end
        end
        StYears: begin
          // Advance one year per cycle until the held year
          if (year_q < held_q.yr) begin
            days_q <= add_sum;
            year_q <= year_q + 8'd1;
          end else begin
            state_q <= StMonth;
          end
        end
        StMonth: begin
          days_q  <= add_sum;
          state_q <= StMul;
        end
        StMul: begin
          acc_q   <= prod_full;
          tod_q   <= 12'(held_q.hr) * 12'(SecPerMin) + 12'(held_q.min);
          state_q <= StTod;
        end
        StTod: begin
          acc_q   <= add_sum;
          state_q <= StFinish;
        end
        StFinish: begin
          // Hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_item_q.timestamp <= (status_q == StatRange) ? 32'd0 : add_sum;
            out_item_q.status    <= status_q;
            out_valid_q          <= 1'b1;
            state_q              <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input still ready after accepting an item");

  a_year_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StYears) |-> (year_q <= held_q.yr))
    else $error("year walk passed the held year");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.item.status == StatRange)) |-> (out_o.item.timestamp == 32'd0))
    else $error("out-of-range result carries a nonzero timestamp");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.item.status != 2'd3))
    else $error("result status uses an undefined code");

endmodule

// File: src/bcdcal_decode.sv
// ----------------------------------------------------------------------------
// bcdcal_decode: BCD register byte decoder
// Masks the tens digit of each register byte and folds it with the units
// nibble into a binary calendar time. Units above 9 pass through as is.
// ----------------------------------------------------------------------------
module bcdcal_decode (
  input  bcdcal_pkg::in_item_t  item_i,
  output bcdcal_pkg::cal_time_t time_o
);
  import bcdcal_pkg::*;

  // Tens times ten plus units, per field tens mask
  always_comb begin
    time_o.sec = 7'(item_i.seconds_reg[6:4]) * 7'd10 + 7'(item_i.seconds_reg[3:0]);
    time_o.min = 7'(item_i.minutes_reg[6:4]) * 7'd10 + 7'(item_i.minutes_reg[3:0]);
    time_o.hr  = 6'(item_i.hours_reg[5:4]) * 6'd10 + 6'(item_i.hours_reg[3:0]);
    time_o.day = 6'(item_i.day_reg[5:4]) * 6'd10 + 6'(item_i.day_reg[3:0]);
    time_o.mon = (item_i.month_reg[4] ? 5'd10 : 5'd0) + 5'(item_i.month_reg[3:0]);
    time_o.yr  = 8'(item_i.year_reg[7:4]) * 8'd10 + 8'(item_i.year_reg[3:0]);
  end

endmodule
